[rtl/dqpe_pkg.sv]
// shared types and constants for the positional-edit deque
package dqpe_pkg;

  localparam int unsigned DepthDefault      = 64;
  localparam int unsigned HandleBitsDefault = 16;

  localparam int unsigned KindW   = 4;
  localparam int unsigned ValueW  = 16;
  localparam int unsigned PosW    = 6;
  localparam int unsigned RunW    = 7;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CountW  = 7;

  typedef enum logic [KindW-1:0] {
    KIND_PUSH_FRONT  = 4'd0,
    KIND_PUSH_BACK   = 4'd1,
    KIND_INSERT_AT   = 4'd2,
    KIND_POP_FRONT   = 4'd3,
    KIND_POP_BACK    = 4'd4,
    KIND_REMOVE_AT   = 4'd5,
    KIND_ROTATE      = 4'd6,
    KIND_REV_FIRST   = 4'd7,
    KIND_REV_LAST    = 4'd8
  } kind_e;

  typedef enum logic [StatusW-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2,
    STATUS_BADRV = 2'd3
  } status_e;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_WAIT,
    ST_WA,
    ST_WB,
    ST_FIN
  } state_e;

endpackage

[rtl/deque_with_positional_edits_core.sv]
// deque of handles in a circular memory with positional insert, remove and reversal
//
// Usage: raise start while busy is low; the request is taken at that edge and
// exactly one result follows with done_o high for a single cycle; it cannot be
// stalled. done_o is high in the first cycle after busy falls.
// Insert and remove move one entry at a time: a read, then a write of the value
// read. A reversal of N swaps floor(N/2) pairs (two reads, two writes each).
// The longest requests are a remove at the front and a full reversal.
// The memory has one read port with registered data and one write port.
// Entries are only read within the held range, so the memory needs no clearing.
module deque_with_positional_edits_core #(
  parameter int unsigned DEPTH       = dqpe_pkg::DepthDefault,
  parameter int unsigned HANDLE_BITS = dqpe_pkg::HandleBitsDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [dqpe_pkg::KindW-1:0]   kind_i,
  input  logic [dqpe_pkg::ValueW-1:0]  entry_value_i,
  input  logic [dqpe_pkg::PosW-1:0]    position_i,
  input  logic [dqpe_pkg::RunW-1:0]    run_length_i,
  output logic                         done_o,
  output logic [dqpe_pkg::StatusW-1:0] status_o,
  output logic [dqpe_pkg::ValueW-1:0]  result_value_o,
  output logic [dqpe_pkg::CountW-1:0]  entry_count_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned HW = HANDLE_BITS;
  localparam int unsigned EW = (CW > dqpe_pkg::RunW) ? CW : dqpe_pkg::RunW;

  // memory
  logic [HW-1:0] mem [DEPTH];
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [HW-1:0] wdata, rdata_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  // control state
  dqpe_pkg::state_e state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] lo_q, lo_d, hi_q, hi_d;
  logic [dqpe_pkg::KindW-1:0] kind_q, kind_d;
  logic [HW-1:0] val_q, val_d, tmp_q, tmp_d;
  logic [dqpe_pkg::StatusW-1:0] st_q, st_d;
  logic [HW-1:0] res_q, res_d;
  logic done_q, done_d;

  // logical index to slot, wrap at depth
  function automatic logic [AW-1:0] slot(input logic [AW-1:0] h, input logic [CW-1:0] i);
    logic [CW:0] s;
    begin
      s = {{(CW+1-AW){1'b0}}, h} + {1'b0, i};
      if (s >= (CW+1)'(DEPTH)) s = s - (CW+1)'(DEPTH);
      slot = s[AW-1:0];
    end
  endfunction

  // request fields and count at a common width for the range checks
  logic [EW-1:0] pos_w, run_w, cnt_w;
  assign pos_w = EW'(position_i);
  assign run_w = EW'(run_length_i);
  assign cnt_w = EW'(count_q);

  assign busy = (state_q != dqpe_pkg::ST_IDLE);

  // next state and datapath
  always_comb begin
    state_d = state_q; count_d = count_q; head_d = head_q;
    lo_d = lo_q; hi_d = hi_q; kind_d = kind_q; val_d = val_q; tmp_d = tmp_q;
    st_d = st_q; res_d = res_q; done_d = 1'b0;
    we = 1'b0; waddr = '0; wdata = '0; raddr = '0;
    unique case (state_q)
      dqpe_pkg::ST_IDLE: begin
        if (start) begin
          kind_d = kind_i; val_d = HW'(entry_value_i);
          st_d = dqpe_pkg::STATUS_OK; res_d = '0;
          state_d = dqpe_pkg::ST_FIN;
          unique case (kind_i)
            dqpe_pkg::KIND_PUSH_FRONT, dqpe_pkg::KIND_PUSH_BACK,
            dqpe_pkg::KIND_INSERT_AT: begin
              if (count_q >= CW'(DEPTH)) st_d = dqpe_pkg::STATUS_FULL;
              else begin
                // walk from back to position: hi=dest index, lo=target
                hi_d = count_q;
                if (kind_i == dqpe_pkg::KIND_PUSH_FRONT) begin
                  head_d = slot(head_q, CW'(DEPTH - 1));
                  lo_d = '0; hi_d = '0;
                end else if (kind_i == dqpe_pkg::KIND_PUSH_BACK) lo_d = count_q;
                else lo_d = (pos_w > cnt_w) ? count_q : CW'(position_i);
                count_d = count_q + 1'b1;
                state_d = dqpe_pkg::ST_RD;
              end
            end
            dqpe_pkg::KIND_POP_FRONT, dqpe_pkg::KIND_POP_BACK,
            dqpe_pkg::KIND_REMOVE_AT, dqpe_pkg::KIND_ROTATE: begin
              if (count_q == '0) st_d = dqpe_pkg::STATUS_EMPTY;
              else begin
                hi_d = count_q - 1'b1;
                if (kind_i == dqpe_pkg::KIND_POP_BACK) lo_d = count_q - 1'b1;
                else if (kind_i == dqpe_pkg::KIND_REMOVE_AT)
                  lo_d = (pos_w >= cnt_w) ? count_q - 1'b1 : CW'(position_i);
                else lo_d = '0;
                state_d = dqpe_pkg::ST_RD;
              end
            end
            dqpe_pkg::KIND_REV_FIRST, dqpe_pkg::KIND_REV_LAST: begin
              if (run_w == '0 || run_w > cnt_w) st_d = dqpe_pkg::STATUS_BADRV;
              else begin
                if (kind_i == dqpe_pkg::KIND_REV_FIRST) begin
                  lo_d = '0; hi_d = CW'(run_length_i) - 1'b1;
                end else begin
                  lo_d = count_q - CW'(run_length_i); hi_d = count_q - 1'b1;
                end
                state_d = dqpe_pkg::ST_RD;
              end
            end
            default: ;
          endcase
        end
      end
      dqpe_pkg::ST_RD: begin
        priority if (kind_q <= dqpe_pkg::KIND_INSERT_AT) begin
          // insert: shift entry hi-1 to hi until hi reaches lo
          if (hi_q == lo_q) begin
            we = 1'b1; waddr = slot(head_q, lo_q); wdata = val_q;
            state_d = dqpe_pkg::ST_FIN;
          end else begin
            raddr = slot(head_q, hi_q - 1'b1);
            state_d = dqpe_pkg::ST_WAIT;
          end
        end else if (kind_q <= dqpe_pkg::KIND_ROTATE) begin
          // removal family: read the target first; pop front and rotate then finish, the others shift down
          raddr = slot(head_q, lo_q);
          state_d = dqpe_pkg::ST_WAIT;
        end else begin
          if (lo_q >= hi_q) state_d = dqpe_pkg::ST_FIN;
          else begin
            raddr = slot(head_q, lo_q);
            state_d = dqpe_pkg::ST_WAIT;
          end
        end
      end
      dqpe_pkg::ST_WAIT: begin
        priority if (kind_q <= dqpe_pkg::KIND_INSERT_AT) begin
          we = 1'b1; waddr = slot(head_q, hi_q); wdata = rdata_q;
          hi_d = hi_q - 1'b1;
          state_d = dqpe_pkg::ST_RD;
        end else if (kind_q <= dqpe_pkg::KIND_ROTATE) begin
          res_d = rdata_q;
          if (kind_q == dqpe_pkg::KIND_POP_FRONT) begin
            head_d = slot(head_q, CW'(1)); count_d = count_q - 1'b1;
            state_d = dqpe_pkg::ST_FIN;
          end else if (kind_q == dqpe_pkg::KIND_ROTATE) begin
            we = 1'b1; waddr = slot(head_q, count_q); wdata = rdata_q;
            head_d = slot(head_q, CW'(1));
            state_d = dqpe_pkg::ST_FIN;
          end else begin
            count_d = count_q - 1'b1;
            state_d = dqpe_pkg::ST_WA;
          end
        end else begin
          // hold low entry, fetch high entry
          tmp_d = rdata_q;
          raddr = slot(head_q, hi_q);
          state_d = dqpe_pkg::ST_WA;
        end
      end
      dqpe_pkg::ST_WA: begin
        if (kind_q >= dqpe_pkg::KIND_REV_FIRST) begin
          we = 1'b1; waddr = slot(head_q, lo_q); wdata = rdata_q;
          state_d = dqpe_pkg::ST_WB;
        end else begin
          // shift down: entry lo+1 into lo while lo < hi
          if (lo_q >= hi_q) state_d = dqpe_pkg::ST_FIN;
          else begin
            raddr = slot(head_q, lo_q + 1'b1);
            state_d = dqpe_pkg::ST_WB;
          end
        end
      end
      dqpe_pkg::ST_WB: begin
        if (kind_q >= dqpe_pkg::KIND_REV_FIRST) begin
          we = 1'b1; waddr = slot(head_q, hi_q); wdata = tmp_q;
          lo_d = lo_q + 1'b1; hi_d = hi_q - 1'b1;
          state_d = dqpe_pkg::ST_RD;
        end else begin
          we = 1'b1; waddr = slot(head_q, lo_q); wdata = rdata_q;
          lo_d = lo_q + 1'b1;
          state_d = dqpe_pkg::ST_WA;
        end
      end
      dqpe_pkg::ST_FIN: begin
        done_d = 1'b1;
        state_d = dqpe_pkg::ST_IDLE;
      end
      default: state_d = dqpe_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dqpe_pkg::ST_IDLE;
      count_q <= '0;
      head_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      head_q  <= head_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q <= lo_d; hi_q <= hi_d; kind_q <= kind_d; val_q <= val_d;
    tmp_q <= tmp_d; st_q <= st_d; res_q <= res_d;
  end

  // result ports
  assign done_o         = done_q;
  assign status_o       = st_q;
  assign result_value_o = dqpe_pkg::ValueW'(res_q);
  assign entry_count_o  = dqpe_pkg::CountW'(count_q);

`ifndef NO_ASSERTIONS
  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH)) else $error("count above depth");
  a_done_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result held two cycles");
  a_idle_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |=> (count_q == $past(count_q)) || $past(start)) else $error("count moved idle");
`endif

endmodule

[bench/tb_deque_with_positional_edits_core.sv]
// testbench for the positional-edit deque core: random and directed requests against a predictor
`timescale 1ns / 100ps

module tb_deque_with_positional_edits_core;

  localparam int unsigned Depth = dqpe_pkg::DepthDefault;
  // a kind code outside the defined set
  localparam logic [dqpe_pkg::KindW-1:0] KindUnused = 4'hf;

  typedef struct packed {
    logic [dqpe_pkg::KindW-1:0]  kind;
    logic [dqpe_pkg::ValueW-1:0] entry_value;
    logic [dqpe_pkg::PosW-1:0]   position;
    logic [dqpe_pkg::RunW-1:0]   run_length;
  } request_t;

  typedef struct packed {
    logic [dqpe_pkg::StatusW-1:0] status;
    logic [dqpe_pkg::ValueW-1:0]  result_value;
    logic [dqpe_pkg::CountW-1:0]  entry_count;
  } outcome_t;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  logic [dqpe_pkg::KindW-1:0]   kind_i;
  logic [dqpe_pkg::ValueW-1:0]  entry_value_i;
  logic [dqpe_pkg::PosW-1:0]    position_i;
  logic [dqpe_pkg::RunW-1:0]    run_length_i;
  logic                         done_o;
  logic [dqpe_pkg::StatusW-1:0] status_o;
  logic [dqpe_pkg::ValueW-1:0]  result_value_o;
  logic [dqpe_pkg::CountW-1:0]  entry_count_o;

  request_t pending_requests[$];
  outcome_t expected_outcomes[$];
  int       idle_pct;
  bit       hold_off;
  bit       failed;
  bit       stim_done;

  // predictor copy of the deque, kept as a plain ordered list
  logic [dqpe_pkg::ValueW-1:0] shadow_list[$];

  deque_with_positional_edits_core DUT (
    .clk_i, .rst_ni, .start, .busy, .kind_i, .entry_value_i, .position_i,
    .run_length_i, .done_o, .status_o, .result_value_o, .entry_count_o
  );

  // clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // reverse n entries starting at index first
  function automatic void reverse_span(int first, int n);
    int lo;
    int hi;
    logic [dqpe_pkg::ValueW-1:0] t;
    lo = first;
    hi = first + n - 1;
    while (lo < hi) begin
      t = shadow_list[lo];
      shadow_list[lo] = shadow_list[hi];
      shadow_list[hi] = t;
      lo++;
      hi--;
    end
  endfunction

  // compute the outcome of one request and update the shadow list
  function automatic outcome_t predict_deque(request_t r);
    outcome_t o;
    int n;
    int p;
    o.status = dqpe_pkg::STATUS_OK;
    o.result_value = '0;
    n = shadow_list.size();
    case (r.kind)
      dqpe_pkg::KIND_PUSH_FRONT, dqpe_pkg::KIND_PUSH_BACK, dqpe_pkg::KIND_INSERT_AT: begin
        if (n >= Depth) o.status = dqpe_pkg::STATUS_FULL;
        else if (r.kind == dqpe_pkg::KIND_PUSH_FRONT) shadow_list.push_front(r.entry_value);
        else if (r.kind == dqpe_pkg::KIND_PUSH_BACK) shadow_list.push_back(r.entry_value);
        else begin
          p = (r.position > n) ? n : int'(r.position);
          shadow_list.insert(p, r.entry_value);
        end
      end
      dqpe_pkg::KIND_POP_FRONT, dqpe_pkg::KIND_POP_BACK, dqpe_pkg::KIND_REMOVE_AT,
      dqpe_pkg::KIND_ROTATE: begin
        if (n == 0) o.status = dqpe_pkg::STATUS_EMPTY;
        else if (r.kind == dqpe_pkg::KIND_POP_FRONT) o.result_value = shadow_list.pop_front();
        else if (r.kind == dqpe_pkg::KIND_POP_BACK) o.result_value = shadow_list.pop_back();
        else if (r.kind == dqpe_pkg::KIND_ROTATE) begin
          o.result_value = shadow_list.pop_front();
          shadow_list.push_back(o.result_value);
        end else begin
          p = (r.position >= n) ? n - 1 : int'(r.position);
          o.result_value = shadow_list[p];
          shadow_list.delete(p);
        end
      end
      dqpe_pkg::KIND_REV_FIRST, dqpe_pkg::KIND_REV_LAST: begin
        if (r.run_length == 0 || r.run_length > n) o.status = dqpe_pkg::STATUS_BADRV;
        else if (r.kind == dqpe_pkg::KIND_REV_FIRST) reverse_span(0, r.run_length);
        else reverse_span(n - r.run_length, r.run_length);
      end
      default: ;
    endcase
    o.entry_count = dqpe_pkg::CountW'(shadow_list.size());
    return o;
  endfunction

  function automatic request_t make_req(logic [dqpe_pkg::KindW-1:0] k, int v, int p, int n);
    request_t r;
    r.kind = k;
    r.entry_value = dqpe_pkg::ValueW'(v);
    r.position = dqpe_pkg::PosW'(p);
    r.run_length = dqpe_pkg::RunW'(n);
    return r;
  endfunction

  // random request, weighted by a push bias to visit empty and full
  function automatic request_t random_req(int bias);
    request_t r;
    int sel;
    r.entry_value = dqpe_pkg::ValueW'($urandom);
    r.position = dqpe_pkg::PosW'($urandom);
    r.run_length = ($urandom_range(0, 3) == 0) ? dqpe_pkg::RunW'($urandom_range(0, 127))
                                               : dqpe_pkg::RunW'($urandom_range(0, 66));
    sel = $urandom_range(0, 99);
    if (sel < 3) r.kind = dqpe_pkg::KindW'($urandom_range(9, 15));
    else if (sel < 3 + bias) r.kind = dqpe_pkg::KindW'($urandom_range(0, 2));
    else if (sel < 70) r.kind = dqpe_pkg::KindW'($urandom_range(3, 6));
    else r.kind = dqpe_pkg::KindW'($urandom_range(7, 8));
    return r;
  endfunction

  // driver: offers the next pending request, honoring idle percentage and hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
      kind_i <= '0;
      entry_value_i <= '0;
      position_i <= '0;
      run_length_i <= '0;
    end else begin
      if (start && !busy) begin
        expected_outcomes.push_back(predict_deque(pending_requests.pop_front()));
      end
      if ((start && !busy) || !start) begin
        if (pending_requests.size() != 0 && !hold_off &&
            $urandom_range(0, 99) >= idle_pct) begin
          start <= 1'b1;
          kind_i <= pending_requests[0].kind;
          entry_value_i <= pending_requests[0].entry_value;
          position_i <= pending_requests[0].position;
          run_length_i <= pending_requests[0].run_length;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result with the oldest expectation
  always @(posedge clk_i) begin
    outcome_t e;
    if (rst_ni && done_o) begin
      if (expected_outcomes.size() == 0) begin
        $error("result with no request outstanding");
        failed = 1'b1;
      end else begin
        e = expected_outcomes.pop_front();
        if (status_o !== e.status) begin
          $error("status expected %0d actual %0d", e.status, status_o);
          failed = 1'b1;
        end
        if (result_value_o !== e.result_value) begin
          $error("result_value expected %0h actual %0h", e.result_value, result_value_o);
          failed = 1'b1;
        end
        if (entry_count_o !== e.entry_count) begin
          $error("entry_count expected %0d actual %0d", e.entry_count, entry_count_o);
          failed = 1'b1;
        end
      end
    end
  end

  // wait until every request is accepted and answered
  task automatic drain_all();
    while (pending_requests.size() != 0 || start || expected_outcomes.size() != 0)
      @(posedge clk_i);
  endtask

  // stimulus
  initial begin
    int bias;
    failed = 1'b0;
    stim_done = 1'b0;
    hold_off = 1'b0;
    idle_pct = 0;
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: errors on empty, small edits, an unused kind, then fill to full and edit
    pending_requests.push_back(make_req(dqpe_pkg::KIND_POP_FRONT, 0, 0, 0));
    pending_requests.push_back(make_req(dqpe_pkg::KIND_POP_BACK, 0, 0, 0));
    pending_requests.push_back(make_req(dqpe_pkg::KIND_REMOVE_AT, 0, 63, 0));
    pending_requests.push_back(make_req(dqpe_pkg::KIND_ROTATE, 0, 0, 0));
    pending_requests.push_back(make_req(dqpe_pkg::KIND_REV_FIRST, 0, 0, 1));
    pending_requests.push_back(make_req(dqpe_pkg::KIND_PUSH_BACK, 'hffff, 0, 0));
    pending_requests.push_back(make_req(dqpe_pkg::KIND_ROTATE, 0, 0, 0));
    pending_requests.push_back(make_req(dqpe_pkg::KIND_REV_LAST, 0, 0, 1));
    pending_requests.push_back(make_req(dqpe_pkg::KIND_PUSH_FRONT, 0, 0, 0));
    pending_requests.push_back(make_req(dqpe_pkg::KIND_INSERT_AT, 'h5a5a, 63, 0));
    pending_requests.push_back(make_req(dqpe_pkg::KIND_INSERT_AT, 'ha5a5, 0, 0));
    pending_requests.push_back(make_req(dqpe_pkg::KIND_REV_FIRST, 0, 0, 0));
    pending_requests.push_back(make_req(dqpe_pkg::KIND_REV_LAST, 0, 0, 5));
    pending_requests.push_back(make_req(dqpe_pkg::KIND_REV_LAST, 0, 0, 4));
    pending_requests.push_back(make_req(dqpe_pkg::KIND_REMOVE_AT, 0, 63, 0));
    pending_requests.push_back(make_req(dqpe_pkg::KIND_REMOVE_AT, 0, 1, 0));
    pending_requests.push_back(make_req(KindUnused, 'hffff, 63, 127));
    for (int i = 0; i < 63; i++)
      pending_requests.push_back(make_req(dqpe_pkg::KIND_INSERT_AT, $urandom, $urandom, 0));
    pending_requests.push_back(make_req(dqpe_pkg::KIND_PUSH_FRONT, 1, 0, 0));
    pending_requests.push_back(make_req(dqpe_pkg::KIND_PUSH_BACK, 2, 0, 0));
    pending_requests.push_back(make_req(dqpe_pkg::KIND_INSERT_AT, 3, 0, 0));
    pending_requests.push_back(make_req(dqpe_pkg::KIND_REV_FIRST, 0, 0, 64));
    pending_requests.push_back(make_req(dqpe_pkg::KIND_REV_LAST, 0, 0, 65));
    pending_requests.push_back(make_req(dqpe_pkg::KIND_REMOVE_AT, 0, 0, 0));
    drain_all();

    // random phases with different idle rates; fill bias swings the count
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1) ? 66 : (ph == 3) ? 20 : 0;
      for (int i = 0; i < 450; i++) begin
        bias = ((i / 90) % 2 == 0) ? 50 : 12;
        pending_requests.push_back(random_req(bias));
      end
      if (ph == 1) begin
        // pause mid-phase until every outstanding result is back
        while (pending_requests.size() > 225) @(posedge clk_i);
        hold_off = 1'b1;
        while (start || expected_outcomes.size() != 0) @(posedge clk_i);
        repeat (20) @(posedge clk_i);
        hold_off = 1'b0;
      end
      drain_all();
    end

    repeat (400) @(posedge clk_i);
    stim_done = 1'b1;
    if (!failed && expected_outcomes.size() == 0) begin
      $display("PASS deque_with_positional_edits_core");
    end else begin
      $display("FAIL deque_with_positional_edits_core");
    end
    $finish;
  end

  // overall time limit
  initial begin
    #20ms;
    if (!stim_done) begin
      $display("FAIL deque_with_positional_edits_core");
      $finish;
    end
  end

endmodule
